// ===== hdl/affa_pkg.sv =====
// Package for the aligned first-fit allocator: widths, command and status codes, FSM states.
// No dependencies.
package affa_pkg;
   localparam int MaxBlocksDefault = 64;
   localparam int AddrBitsDefault  = 32;
   localparam logic [31:0] PoolSizeReset = 32'd268435456;

   typedef enum logic [1:0] {
      CMD_ALLOC  = 2'd0,
      CMD_FREE   = 2'd1,
      CMD_REINIT = 2'd2,
      CMD_NONE   = 2'd3
   } cmd_type;

   typedef enum logic [1:0] {
      ST_OK       = 2'd0,
      ST_NOFIT    = 2'd1,
      ST_FULL     = 2'd2,
      ST_NOTFOUND = 2'd3
   } status_type;

   typedef enum logic [3:0] {
      S_IDLE,
      S_SCAN_RD,
      S_SCAN_CHK,
      S_SHIFT_RD,
      S_SHIFT_WR,
      S_PUT,
      S_NBR_RD,
      S_NBR_CHK,
      S_CLOSE_RD,
      S_CLOSE_WR,
      S_DONE
   } state_type;

   localparam logic [1:0] CSR_POOL_SIZE = 2'd0;
endpackage

// ===== hdl/affa_if.sv =====
// Valid/ready channel interfaces for the allocator.
// Depends on nothing; payload widths are fixed by the item fields.
interface affa_req_if;
   logic        valid;
   logic        ready;
   logic [1:0]  command;
   logic [31:0] request_size;
   logic [4:0]  align_log2;
   logic [31:0] free_offset;
   modport source (output valid, command, request_size, align_log2, free_offset, input ready);
   modport sink   (input valid, command, request_size, align_log2, free_offset, output ready);
endinterface

interface affa_rsp_if;
   logic        valid;
   logic        ready;
   logic [31:0] alloc_offset;
   logic [1:0]  status;
   modport source (output valid, alloc_offset, status, input ready);
   modport sink   (input valid, alloc_offset, status, output ready);
endinterface

// ===== hdl/aligned_first_fit_allocator_top.sv =====
// Aligned first-fit allocator: one command at a time over a block table held in one RAM.
// Allocate reads and checks each scanned entry, then shifts entries to open a slot (two shift passes at most);
// free adds a left and right neighbor check and one close pass; the single table read port sets the pace.
// Throughput: ready stays low from acceptance until the result word is taken.
// Synchronous reset restores one free block of pool_size (reset 268435456), entry 0 is
// written while reset is held. Depends on affa_pkg, affa_if and affa_table.
module aligned_first_fit_allocator_top #(
   parameter int MAX_BLOCKS = affa_pkg::MaxBlocksDefault,
   parameter int ADDR_BITS  = affa_pkg::AddrBitsDefault
) (
   input  logic        clock,
   input  logic        reset,
   affa_req_if.sink    req,
   affa_rsp_if.source  rsp,
   input  logic        csr_psel,
   input  logic        csr_penable,
   input  logic        csr_pwrite,
   input  logic [1:0]  csr_paddr,
   input  logic [31:0] csr_pwdata,
   output logic [31:0] csr_prdata,
   output logic        csr_pready
);
   localparam int IdxBits = $clog2(MAX_BLOCKS);
   localparam int CntBits = $clog2(MAX_BLOCKS + 1);
   localparam int AW      = ADDR_BITS;

   // control registers
   affa_pkg::state_type state_ff, state_in;
   logic [CntBits-1:0] count_ff, count_in;
   logic [CntBits-1:0] idx_ff, idx_in;     // entry under scan / hole position
   logic [CntBits-1:0] sh_ff, sh_in;       // shift cursor
   logic [1:0]         phase_ff, phase_in; // 0 head split, 1 tail split, 2 mark
   logic               rsp_valid_ff, rsp_valid_in;
   logic [31:0]        pool_ff;

   // payload registers
   logic [1:0]    cmd_ff, cmd_in;
   logic [AW-1:0] size_ff, size_in, mask_ff, mask_in, key_ff, key_in;
   logic [AW-1:0] s_ff, s_in, e_ff, e_in, a_ff, a_in;
   logic          lmrg_ff, lmrg_in;       // freed block merged into its left neighbor
   logic [1:0]    gap_ff, gap_in;         // entries absorbed by the merge
   logic [AW-1:0] acc_ff, acc_in;         // length of merged block
   logic [31:0]   off_ff, off_in;
   logic [1:0]    st_ff, st_in;

   // table port
   logic               wr_en;
   logic [IdxBits-1:0] wr_idx, rd_idx;
   logic [AW-1:0]      wr_start, wr_len, rd_start, rd_len;
   logic               wr_free, rd_free;

   affa_table #(.MAX_BLOCKS(MAX_BLOCKS), .ADDR_BITS(ADDR_BITS)) u_table (
      .clock, .wr_en, .wr_idx, .wr_start, .wr_len, .wr_free,
      .rd_idx, .rd_start, .rd_len, .rd_free
   );

   logic req_fire, rsp_fire;
   assign req_fire = req.valid && req.ready;
   assign rsp_fire = rsp.valid && rsp.ready;
   assign req.ready = (state_ff == affa_pkg::S_IDLE) && !rsp_valid_ff;
   assign rsp.valid = rsp_valid_ff;
   assign rsp.alloc_offset = off_ff;
   assign rsp.status = st_ff;

   assign csr_pready = 1'b1;
   assign csr_prdata = (csr_paddr == affa_pkg::CSR_POOL_SIZE) ? pool_ff : 32'd0;

   // shared adder/compare datapath on the entry just read
   logic [AW:0] end_w, aln_w, asz_w;
   logic        fits;
   assign end_w = {1'b0, rd_start} + {1'b0, rd_len};
   assign aln_w = ({1'b0, rd_start} + {1'b0, mask_ff}) & ~{1'b0, mask_ff};
   assign asz_w = aln_w + {1'b0, size_ff};
   assign fits  = rd_free && (aln_w < end_w) && (asz_w <= end_w);

   logic [AW-1:0] a_sz;
   assign a_sz = a_ff + size_ff;
   logic [1:0] need;
   assign need = {1'b0, (a_ff != s_ff)} + {1'b0, (a_sz != e_ff)};

   // merge bookkeeping for free: right neighbor test, final position, new count
   logic               rmrg;
   logic [CntBits-1:0] fpos, ncount;
   logic [1:0]         gap_w;
   assign rmrg   = (idx_ff + 1'b1 < count_ff) && rd_free;
   assign fpos   = lmrg_ff ? idx_ff - 1'b1 : idx_ff;
   assign gap_w  = {1'b0, lmrg_ff} + {1'b0, rmrg};
   assign ncount = count_ff - CntBits'(gap_w);

   always_ff @(posedge clock) begin
      if (reset) begin
         pool_ff <= affa_pkg::PoolSizeReset;
      end else if (csr_psel && csr_penable && csr_pwrite
                   && csr_paddr == affa_pkg::CSR_POOL_SIZE) begin
         pool_ff <= csr_pwdata;
      end
   end

   // next state
   always_comb begin
      state_in = state_ff;
      case (state_ff)
         affa_pkg::S_IDLE: begin
            if (req_fire) begin
               case (affa_pkg::cmd_type'(req.command))
                  affa_pkg::CMD_ALLOC:
                     state_in = (AW'(req.request_size) == '0) ? affa_pkg::S_DONE
                                                             : affa_pkg::S_SCAN_RD;
                  affa_pkg::CMD_FREE: state_in = affa_pkg::S_SCAN_RD;
                  default:            state_in = affa_pkg::S_DONE;
               endcase
            end
         end
         affa_pkg::S_SCAN_RD:
            state_in = (idx_ff >= count_ff) ? affa_pkg::S_DONE : affa_pkg::S_SCAN_CHK;
         affa_pkg::S_SCAN_CHK: begin
            if (cmd_ff == affa_pkg::CMD_ALLOC) begin
               state_in = fits ? affa_pkg::S_PUT : affa_pkg::S_SCAN_RD;
            end else begin
               state_in = (rd_start == key_ff) ? affa_pkg::S_NBR_RD : affa_pkg::S_SCAN_RD;
            end
         end
         affa_pkg::S_PUT: begin
            if (phase_ff == 2'd0 && count_ff + CntBits'(need) > CntBits'(MAX_BLOCKS))
               state_in = affa_pkg::S_DONE;
            else if (phase_ff == 2'd2)
               state_in = affa_pkg::S_DONE;
            else if ((phase_ff == 2'd0 && a_ff != s_ff) || a_sz != e_ff)
               state_in = (sh_ff > idx_ff + 1'b1) ? affa_pkg::S_SHIFT_RD : affa_pkg::S_PUT;
            else
               state_in = affa_pkg::S_PUT;
         end
         affa_pkg::S_SHIFT_RD: state_in = affa_pkg::S_SHIFT_WR;
         affa_pkg::S_SHIFT_WR:
            state_in = (sh_ff - 1'b1 > idx_ff + 1'b1) ? affa_pkg::S_SHIFT_RD : affa_pkg::S_PUT;
         affa_pkg::S_NBR_RD: state_in = affa_pkg::S_NBR_CHK;
         affa_pkg::S_NBR_CHK: begin
            if (phase_ff == 2'd0) state_in = affa_pkg::S_NBR_RD;
            else state_in = (gap_w != 2'd0 && fpos + 1'b1 < ncount) ? affa_pkg::S_CLOSE_RD
                                                                   : affa_pkg::S_DONE;
         end
         affa_pkg::S_CLOSE_RD: state_in = affa_pkg::S_CLOSE_WR;
         affa_pkg::S_CLOSE_WR:
            state_in = (sh_ff + 1'b1 < count_ff) ? affa_pkg::S_CLOSE_RD : affa_pkg::S_DONE;
         affa_pkg::S_DONE: state_in = affa_pkg::S_IDLE;
         default: state_in = affa_pkg::S_IDLE;
      endcase
   end

   // datapath and table control
   always_comb begin
      count_in = count_ff; idx_in = idx_ff; sh_in = sh_ff; phase_in = phase_ff;
      cmd_in = cmd_ff; size_in = size_ff; mask_in = mask_ff; key_in = key_ff;
      s_in = s_ff; e_in = e_ff; a_in = a_ff; lmrg_in = lmrg_ff; gap_in = gap_ff;
      acc_in = acc_ff; off_in = off_ff; st_in = st_ff;
      rsp_valid_in = rsp_valid_ff && !rsp_fire;
      wr_en = 1'b0; wr_idx = '0; wr_start = '0; wr_len = '0; wr_free = 1'b0;
      rd_idx = idx_ff[IdxBits-1:0];
      case (state_ff)
         affa_pkg::S_IDLE: begin
            if (req_fire) begin
               cmd_in  = req.command;
               size_in = AW'(req.request_size);
               mask_in = AW'((33'd1 << req.align_log2) - 33'd1);
               key_in  = AW'(req.free_offset);
               idx_in  = '0;
               off_in  = '0;
               phase_in = 2'd0;
               lmrg_in = 1'b0;
               st_in = (req.command == affa_pkg::CMD_ALLOC && AW'(req.request_size) == '0)
                       ? affa_pkg::ST_NOFIT : affa_pkg::ST_OK;
               if (req.command == affa_pkg::CMD_REINIT) begin
                  wr_en = 1'b1; wr_idx = '0; wr_len = AW'(pool_ff); wr_free = 1'b1;
                  count_in = CntBits'(1);
               end
            end
         end
         affa_pkg::S_SCAN_RD: begin
            if (idx_ff >= count_ff)
               st_in = (cmd_ff == affa_pkg::CMD_ALLOC) ? affa_pkg::ST_NOFIT
                                                       : affa_pkg::ST_NOTFOUND;
         end
         affa_pkg::S_SCAN_CHK: begin
            s_in = rd_start; e_in = end_w[AW-1:0]; a_in = aln_w[AW-1:0];
            acc_in = rd_len;
            sh_in = count_ff;
            if (!((cmd_ff == affa_pkg::CMD_ALLOC && fits) ||
                  (cmd_ff == affa_pkg::CMD_FREE && rd_start == key_ff)))
               idx_in = idx_ff + 1'b1;
         end
         affa_pkg::S_PUT: begin
            if (phase_ff == 2'd0 && count_ff + CntBits'(need) > CntBits'(MAX_BLOCKS)) begin
               st_in = affa_pkg::ST_FULL;
            end else if (phase_ff == 2'd2) begin
               wr_en = 1'b1; wr_idx = idx_ff[IdxBits-1:0];
               wr_start = a_ff; wr_len = size_ff; wr_free = 1'b0;
               off_in = 32'(a_ff);
            end else if (phase_ff == 2'd0 && a_ff != s_ff) begin
               if (sh_ff <= idx_ff + 1'b1) begin
                  // hole open at idx+1: write the head, move on to the rest
                  wr_en = 1'b1; wr_idx = idx_ff[IdxBits-1:0];
                  wr_start = s_ff; wr_len = a_ff - s_ff; wr_free = 1'b1;
                  count_in = count_ff + 1'b1; idx_in = idx_ff + 1'b1;
                  phase_in = 2'd1; sh_in = count_ff + 1'b1;
               end
            end else if (phase_ff == 2'd1 || phase_ff == 2'd0) begin
               if (a_sz != e_ff) begin
                  if (sh_ff <= idx_ff + 1'b1) begin
                     wr_en = 1'b1; wr_idx = IdxBits'(idx_ff + 1'b1);
                     wr_start = a_sz; wr_len = e_ff - a_sz; wr_free = 1'b1;
                     count_in = count_ff + 1'b1; phase_in = 2'd2;
                  end
               end else begin
                  phase_in = 2'd2;
               end
            end
         end
         affa_pkg::S_SHIFT_RD: rd_idx = IdxBits'(sh_ff - 1'b1);
         affa_pkg::S_SHIFT_WR: begin
            wr_en = 1'b1; wr_idx = sh_ff[IdxBits-1:0];
            wr_start = rd_start; wr_len = rd_len; wr_free = rd_free;
            sh_in = sh_ff - 1'b1;
         end
         affa_pkg::S_NBR_RD: begin
            // phase 0 reads left neighbor, phase 1 reads right neighbor
            rd_idx = (phase_ff == 2'd0) ? IdxBits'(idx_ff - 1'b1) : IdxBits'(idx_ff + 1'b1);
         end
         affa_pkg::S_NBR_CHK: begin
            if (phase_ff == 2'd0) begin
               phase_in = 2'd1;
               if (idx_ff != '0 && rd_free) begin
                  acc_in = rd_len + acc_ff; s_in = rd_start; lmrg_in = 1'b1;
               end
            end else begin
               // write the merged block, then pull the entries behind it down
               wr_en = 1'b1; wr_idx = fpos[IdxBits-1:0];
               wr_start = s_ff; wr_free = 1'b1;
               wr_len = rmrg ? acc_ff + rd_len : acc_ff;
               gap_in = gap_w; count_in = ncount; sh_in = fpos + 1'b1;
               phase_in = 2'd2;
            end
         end
         affa_pkg::S_CLOSE_RD: rd_idx = IdxBits'(sh_ff + CntBits'(gap_ff));
         affa_pkg::S_CLOSE_WR: begin
            wr_en = 1'b1; wr_idx = sh_ff[IdxBits-1:0];
            wr_start = rd_start; wr_len = rd_len; wr_free = rd_free;
            sh_in = sh_ff + 1'b1;
         end
         affa_pkg::S_DONE: begin
            rsp_valid_in = 1'b1;
            if (st_ff != affa_pkg::ST_OK) off_in = '0;
         end
         default: ;
      endcase
      // hold entry 0 at one free block of the reset pool size
      if (reset) begin
         wr_en = 1'b1; wr_idx = '0; wr_start = '0;
         wr_len = AW'(affa_pkg::PoolSizeReset); wr_free = 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= affa_pkg::S_IDLE;
         count_ff <= CntBits'(1);
         idx_ff <= '0; sh_ff <= '0; phase_ff <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff <= state_in;
         count_ff <= count_in;
         idx_ff <= idx_in; sh_ff <= sh_in; phase_ff <= phase_in;
         rsp_valid_ff <= rsp_valid_in;
      end
      cmd_ff <= cmd_in; size_ff <= size_in; mask_ff <= mask_in; key_ff <= key_in;
      s_ff <= s_in; e_ff <= e_in; a_ff <= a_in; lmrg_ff <= lmrg_in; gap_ff <= gap_in;
      acc_ff <= acc_in; off_ff <= off_in; st_ff <= st_in;
   end

   assert property (@(posedge clock) disable iff (reset)
      count_ff != '0 && count_ff <= CntBits'(MAX_BLOCKS)) else $error("block count out of range");
   assert property (@(posedge clock) disable iff (reset)
      req_fire |=> state_ff != affa_pkg::S_IDLE) else $error("request not taken");
   assert property (@(posedge clock) disable iff (reset)
      rsp.valid && rsp.status != affa_pkg::ST_OK |-> rsp.alloc_offset == '0)
      else $error("offset on failed request");
   assert property (@(posedge clock) disable iff (reset)
      rsp.valid |-> !req.ready) else $error("ready while result pending");
   assert property (@(posedge clock) disable iff (reset)
      state_ff == affa_pkg::S_DONE |=> rsp.valid) else $error("result missing");
endmodule

// ===== hdl/affa_table.sv =====
// Block table memory: start, length and free mark, one write and one registered read a cycle.
// Depends on no other file; sized by parameters.
module affa_table #(
   parameter int MAX_BLOCKS = 64,
   parameter int ADDR_BITS  = 32,
   localparam int IdxBits   = $clog2(MAX_BLOCKS)
) (
   input  logic                 clock,
   input  logic                 wr_en,
   input  logic [IdxBits-1:0]   wr_idx,
   input  logic [ADDR_BITS-1:0] wr_start,
   input  logic [ADDR_BITS-1:0] wr_len,
   input  logic                 wr_free,
   input  logic [IdxBits-1:0]   rd_idx,
   output logic [ADDR_BITS-1:0] rd_start,
   output logic [ADDR_BITS-1:0] rd_len,
   output logic                 rd_free
);
   logic [2*ADDR_BITS:0] mem [MAX_BLOCKS];
   logic [2*ADDR_BITS:0] rd_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_idx] <= {wr_free, wr_len, wr_start};
      end
      rd_ff <= mem[rd_idx];
   end

   assign rd_start = rd_ff[ADDR_BITS-1:0];
   assign rd_len   = rd_ff[2*ADDR_BITS-1:ADDR_BITS];
   assign rd_free  = rd_ff[2*ADDR_BITS];
endmodule

// ===== sim/tb_aligned_first_fit_allocator_top.sv =====
// Testbench for the aligned first-fit allocator: directed table then random command traffic,
// every response checked against an in-bench model of the block table.
// Depends on affa_pkg, affa_if and aligned_first_fit_allocator_top.
module tb_aligned_first_fit_allocator_top;
   localparam int NBLK = 64;
   localparam int WATCHDOG = 200000;

   typedef struct packed {
      logic [1:0]  command;
      logic [31:0] request_size;
      logic [4:0]  align_log2;
      logic [31:0] free_offset;
   } req_word_type;

   typedef struct packed {
      logic [31:0] alloc_offset;
      logic [1:0]  status;
   } rsp_word_type;

   typedef struct {
      req_word_type  word;
      logic          typed;
      rsp_word_type  want;
   } stim_row_type;

   logic clock = 1'b0;
   logic reset = 1'b1;
   logic        csr_psel = 1'b0, csr_penable = 1'b0, csr_pwrite = 1'b0;
   logic [1:0]  csr_paddr = '0;
   logic [31:0] csr_pwdata = '0;
   logic [31:0] csr_prdata;
   logic        csr_pready;

   affa_req_if req ();
   affa_rsp_if rsp ();

   aligned_first_fit_allocator_top uut (
      .clock(clock), .reset(reset), .req(req), .rsp(rsp),
      .csr_psel(csr_psel), .csr_penable(csr_penable), .csr_pwrite(csr_pwrite),
      .csr_paddr(csr_paddr), .csr_pwdata(csr_pwdata), .csr_prdata(csr_prdata),
      .csr_pready(csr_pready)
   );

   always #5 clock = ~clock;

   // model of the block table
   logic [31:0] mdl_pool;
   logic [31:0] blk_start [NBLK];
   logic [31:0] blk_len [NBLK];
   logic        blk_free [NBLK];
   int          blk_cnt;

   rsp_word_type pending_rsp[$];
   int           mismatches = 0;
   int           accepted_req = 0, accepted_rsp = 0;
   int           idle_cycles = 0;
   int           n_ok = 0, n_nofit = 0, n_full = 0, n_notfound = 0;
   stim_row_type rows[$];

   function automatic void table_restore();
      blk_cnt = 1;
      blk_start[0] = '0;
      blk_len[0] = mdl_pool;
      blk_free[0] = 1'b1;
   endfunction

   function automatic void slot_open(int p);
      for (int k = blk_cnt; k > p; k--) begin
         blk_start[k] = blk_start[k-1];
         blk_len[k] = blk_len[k-1];
         blk_free[k] = blk_free[k-1];
      end
      blk_cnt++;
   endfunction

   function automatic void slot_close(int p);
      for (int k = p; k + 1 < blk_cnt; k++) begin
         blk_start[k] = blk_start[k+1];
         blk_len[k] = blk_len[k+1];
         blk_free[k] = blk_free[k+1];
      end
      blk_cnt--;
   endfunction

   function automatic rsp_word_type grant_or_release(req_word_type w);
      rsp_word_type r;
      logic [32:0] s, e, a, al, sz;
      int i, need;
      bit found;
      r = '{alloc_offset: '0, status: affa_pkg::ST_OK};
      found = 0;
      i = 0;
      case (affa_pkg::cmd_type'(w.command))
         affa_pkg::CMD_ALLOC: begin
            sz = {1'b0, w.request_size};
            al = 33'd1 << w.align_log2;
            if (sz == 0) begin
               r.status = affa_pkg::ST_NOFIT;
               return r;
            end
            for (i = 0; i < blk_cnt; i++) begin
               if (!blk_free[i]) continue;
               s = {1'b0, blk_start[i]};
               e = s + blk_len[i];
               a = (s + al - 1) & ~(al - 1);
               if (a >= e || a + sz > e) continue;
               found = 1;
               break;
            end
            if (!found) begin
               r.status = affa_pkg::ST_NOFIT;
               return r;
            end
            need = (a > s) + (a + sz < e);
            if (blk_cnt + need > NBLK) begin
               r.status = affa_pkg::ST_FULL;
               return r;
            end
            if (a > s) begin
               slot_open(i + 1);
               blk_start[i+1] = a[31:0];
               blk_len[i+1] = 32'(e - a);
               blk_free[i+1] = 1'b1;
               blk_len[i] = 32'(a - s);
               i++;
            end
            if (a + sz < e) begin
               slot_open(i + 1);
               blk_start[i+1] = 32'(a + sz);
               blk_len[i+1] = 32'(e - (a + sz));
               blk_free[i+1] = 1'b1;
               blk_len[i] = sz[31:0];
            end
            blk_free[i] = 1'b0;
            r.alloc_offset = a[31:0];
         end
         affa_pkg::CMD_FREE: begin
            for (i = 0; i < blk_cnt; i++)
               if (blk_start[i] == w.free_offset) begin
                  found = 1;
                  break;
               end
            if (!found) begin
               r.status = affa_pkg::ST_NOTFOUND;
               return r;
            end
            blk_free[i] = 1'b1;
            if (i > 0 && blk_free[i-1]) begin
               blk_len[i-1] += blk_len[i];
               slot_close(i);
               i--;
            end
            if (i + 1 < blk_cnt && blk_free[i+1]) begin
               blk_len[i] += blk_len[i+1];
               slot_close(i + 1);
            end
         end
         affa_pkg::CMD_REINIT: table_restore();
         default: ;
      endcase
      return r;
   endfunction

   function automatic int gap_len();
      int p;
      p = $urandom_range(0, 99);
      if (p < 40) return 0;
      if (p < 90) return $urandom_range(1, 3);
      return $urandom_range(10, 60);
   endfunction

   // pick a free offset: mostly a live block start, else noise
   function automatic logic [31:0] pick_offset();
      if ($urandom_range(0, 9) < 8) return blk_start[$urandom_range(0, blk_cnt - 1)];
      return $urandom();
   endfunction

   function automatic req_word_type random_word(logic [31:0] pool);
      req_word_type w;
      int p;
      w.request_size = $urandom();
      w.align_log2 = $urandom_range(0, 31);
      w.free_offset = $urandom();
      p = $urandom_range(0, 99);
      if (p < 55) begin
         w.command = affa_pkg::CMD_ALLOC;
         if ($urandom_range(0, 9) < 8) begin
            w.request_size = $urandom_range(1, (pool > 32'd64 ? pool >> $urandom_range(2, 8) : 1));
            w.align_log2 = $urandom_range(0, 8);
         end
      end else if (p < 93) begin
         w.command = affa_pkg::CMD_FREE;
         w.free_offset = pick_offset();
      end else if (p < 97) w.command = affa_pkg::CMD_REINIT;
      else w.command = affa_pkg::CMD_NONE;
      return w;
   endfunction

   // response side: random stall, check against oldest expectation
   initial begin
      int g;
      rsp.ready = 1'b0;
      @(posedge clock iff !reset);
      forever begin
         g = gap_len();
         repeat (g) @(posedge clock) rsp.ready <= 1'b0;
         @(posedge clock) rsp.ready <= 1'b1;
         do @(posedge clock); while (!rsp.valid);
         rsp.ready <= 1'b0;
      end
   end

   always @(posedge clock) begin
      rsp_word_type got, want;
      if (!reset && rsp.valid && rsp.ready) begin
         got = '{alloc_offset: rsp.alloc_offset, status: rsp.status};
         accepted_rsp++;
         if (pending_rsp.size() == 0) begin
            mismatches++;
            if (mismatches <= 10) $display("unexpected response offset=%h status=%0d",
               got.alloc_offset, got.status);
         end else begin
            want = pending_rsp.pop_front();
            if (got.alloc_offset !== want.alloc_offset || got.status !== want.status) begin
               mismatches++;
               if (mismatches <= 10)
                  $display("mismatch: exp offset=%h status=%0d got offset=%h status=%0d",
                     want.alloc_offset, want.status, got.alloc_offset, got.status);
            end
            case (affa_pkg::status_type'(want.status))
               affa_pkg::ST_OK: n_ok++;
               affa_pkg::ST_NOFIT: n_nofit++;
               affa_pkg::ST_FULL: n_full++;
               default: n_notfound++;
            endcase
         end
      end
   end

   always @(posedge clock) begin
      if ((req.valid && req.ready) || (rsp.valid && rsp.ready) || reset) idle_cycles <= 0;
      else idle_cycles <= idle_cycles + 1;
      if (idle_cycles >= WATCHDOG) begin
         $display("watchdog: no handshake in %0d cycles", WATCHDOG);
         $display("Regression FAIL");
         $finish;
      end
   end

   task automatic send_word(req_word_type w, logic typed, rsp_word_type want);
      rsp_word_type pred;
      int g;
      g = gap_len();
      repeat (g) @(posedge clock) req.valid <= 1'b0;
      @(posedge clock);
      req.valid <= 1'b1;
      req.command <= w.command;
      req.request_size <= w.request_size;
      req.align_log2 <= w.align_log2;
      req.free_offset <= w.free_offset;
      do @(posedge clock); while (!req.ready);
      pred = grant_or_release(w);
      if (typed && pred !== want) begin
         mismatches++;
         if (mismatches <= 10) $display("table row disagrees with model: %h vs %h", want, pred);
      end
      pending_rsp.push_back(pred);
      accepted_req++;
      req.valid <= 1'b0;
   endtask

   task automatic drain();
      while (pending_rsp.size() != 0) @(posedge clock);
      repeat (300) @(posedge clock);
   endtask

   task automatic csr_write(logic [31:0] v);
      @(posedge clock);
      csr_psel <= 1'b1; csr_penable <= 1'b0; csr_pwrite <= 1'b1;
      csr_paddr <= affa_pkg::CSR_POOL_SIZE; csr_pwdata <= v;
      @(posedge clock) csr_penable <= 1'b1;
      do @(posedge clock); while (!csr_pready);
      csr_psel <= 1'b0; csr_penable <= 1'b0; csr_pwrite <= 1'b0;
      mdl_pool = v;
   endtask

   function automatic stim_row_type row(affa_pkg::cmd_type c, logic [31:0] sz, logic [4:0] lg,
         logic [31:0] off, logic typed, logic [31:0] o, affa_pkg::status_type st);
      stim_row_type r;
      r.word = '{command: c, request_size: sz, align_log2: lg, free_offset: off};
      r.typed = typed;
      r.want = '{alloc_offset: o, status: st};
      return r;
   endfunction

   initial begin
      logic [31:0] pools [5];
      req.valid = 1'b0;
      req.command = affa_pkg::CMD_NONE;
      req.request_size = '0;
      req.align_log2 = '0;
      req.free_offset = '0;
      mdl_pool = affa_pkg::PoolSizeReset;
      table_restore();
      repeat (10) @(posedge clock);
      reset <= 1'b0;

      rows.push_back(row(affa_pkg::CMD_ALLOC, 32'd0, 5'd0, 0, 1, 0, affa_pkg::ST_NOFIT));
      rows.push_back(row(affa_pkg::CMD_ALLOC, 32'd16, 5'd0, 0, 1, 0, affa_pkg::ST_OK));
      rows.push_back(row(affa_pkg::CMD_ALLOC, 32'd16, 5'd6, 0, 1, 32'd64, affa_pkg::ST_OK));
      rows.push_back(row(affa_pkg::CMD_FREE, 0, 5'd0, 32'd5, 1, 0, affa_pkg::ST_NOTFOUND));
      rows.push_back(row(affa_pkg::CMD_FREE, 0, 5'd0, 32'd0, 0, 0, affa_pkg::ST_OK));
      rows.push_back(row(affa_pkg::CMD_FREE, 0, 5'd0, 32'd0, 0, 0, affa_pkg::ST_OK));
      rows.push_back(row(affa_pkg::CMD_FREE, 0, 5'd0, 32'd64, 0, 0, affa_pkg::ST_OK));
      rows.push_back(row(affa_pkg::CMD_ALLOC, 32'hFFFF_FFFF, 5'd31, 0, 1, 0,
         affa_pkg::ST_NOFIT));
      rows.push_back(row(affa_pkg::CMD_ALLOC, affa_pkg::PoolSizeReset + 32'd1, 5'd0, 0, 1, 0,
         affa_pkg::ST_NOFIT));
      rows.push_back(row(affa_pkg::CMD_ALLOC, affa_pkg::PoolSizeReset, 5'd0, 0, 1, 0,
         affa_pkg::ST_OK));
      rows.push_back(row(affa_pkg::CMD_ALLOC, 32'd1, 5'd0, 0, 1, 0, affa_pkg::ST_NOFIT));
      rows.push_back(row(affa_pkg::CMD_NONE, 32'hFFFF_FFFF, 5'd31, 32'hFFFF_FFFF, 1, 0,
         affa_pkg::ST_OK));
      rows.push_back(row(affa_pkg::CMD_FREE, 0, 5'd0, 32'hFFFF_FFFF, 1, 0,
         affa_pkg::ST_NOTFOUND));
      rows.push_back(row(affa_pkg::CMD_REINIT, 0, 5'd0, 0, 1, 0, affa_pkg::ST_OK));
      rows.push_back(row(affa_pkg::CMD_ALLOC, 32'd3, 5'd4, 0, 0, 0, affa_pkg::ST_OK));
      rows.push_back(row(affa_pkg::CMD_ALLOC, 32'd5, 5'd4, 0, 0, 0, affa_pkg::ST_OK));
      foreach (rows[i]) send_word(rows[i].word, rows[i].typed, rows[i].want);

      // fill the table with small splits to reach the full case
      for (int k = 0; k < 40; k++)
         send_word('{command: affa_pkg::CMD_ALLOC, request_size: 32'd1, align_log2: 5'd3,
            free_offset: 32'h0}, 1'b0, '0);
      drain();

      pools = '{32'd0, 32'd1, 32'hFFFF_FFFF, 32'd4096, 32'd200000};
      foreach (pools[p]) begin
         csr_write(pools[p]);
         send_word('{command: affa_pkg::CMD_REINIT, request_size: 0, align_log2: 0,
            free_offset: 0}, 1'b1, '0);
         for (int k = 0; k < 118; k++) send_word(random_word(pools[p]), 1'b0, '0);
         drain();
      end

      $display("covered %0d requests, %0d responses: ok %0d nofit %0d full %0d notfound %0d",
         accepted_req, accepted_rsp, n_ok, n_nofit, n_full, n_notfound);
      $display("pool sizes swept from zero to all ones with random stalls on both sides");
      if (mismatches == 0 && pending_rsp.size() == 0) begin
         $display("Regression PASS");
      end else begin
         $display("%0d mismatches", mismatches);
         $display("Regression FAIL");
      end
      $finish;
   end
endmodule

// ===== files.f =====
hdl/affa_pkg.sv
hdl/affa_if.sv
hdl/affa_table.sv
hdl/aligned_first_fit_allocator_top.sv
sim/tb_aligned_first_fit_allocator_top.sv
